/* sv/fmv_pkg.sv */
// Shared types, constants and the operator schedule for the four-operator FM voice.
package fmv_pkg;

  // Phase accumulator width, sine resolution and output width.
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  // Field widths fixed by the register map and the channels.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ALG_W     = 2;
  localparam int DEPTH_W   = 12;
  localparam int AMP_W     = 16;
  localparam int SIN_W     = 16;

  // Weighted sum of three Q1.15 sines times Q4.8 depths needs 30 signed bits.
  localparam int W_W = 30;

  // Modulation offset: product shifted right by this many bits.
  localparam int OFFSET_SHIFT = 23;

  // The step is multiplied in two halves.
  localparam int STEP_LO_BITS = PHASE_BITS / 2;
  localparam int STEP_HI_BITS = PHASE_BITS - STEP_LO_BITS;
  localparam int ACC_W        = OFFSET_SHIFT + PHASE_BITS;

  // Shared multiplier: signed A by signed B.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int EXT_W   = 64;

  // Quarter-wave polynomial in Q16.
  localparam int POLY_SHIFT = 16;
  localparam int X_W        = POLY_SHIFT + 1;
  localparam int FRAC_BITS  = SINE_TABLE_BITS - 2;
  localparam int X_SHIFT    = POLY_SHIFT - FRAC_BITS;
  localparam logic [X_W-1:0] X_ONE  = X_W'(65536);
  localparam logic [X_W-1:0] POLY_A = X_W'(102944);
  localparam logic [X_W-1:0] POLY_B = X_W'(42047);
  localparam logic [X_W-1:0] POLY_C = X_W'(4640);
  localparam logic [X_W-1:0] SIN_SCALE = X_W'(32767);
  localparam logic [X_W+POLY_SHIFT-1:0] ROUND_HALF = (X_W + POLY_SHIFT)'(32768);
  localparam logic [X_W-1:0] SIN_MAX = X_W'(32767);

  // The product of sine and amplitude spans SIN_W + AMP_W bits.
  localparam int OUT_MSB = SIN_W + AMP_W - 1;

  localparam int SLOT_W = 3;

  // Operator numbers: the carrier is operator zero.
  localparam logic [1:0] OP_CARRIER = 2'd0;
  localparam logic [1:0] OP_ONE     = 2'd1;
  localparam logic [1:0] OP_TWO     = 2'd2;
  localparam logic [1:0] OP_THREE   = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALGORITHM,
    REG_CARRIER_STEP,
    REG_MOD_ONE_STEP,
    REG_MOD_TWO_STEP,
    REG_MOD_THREE_STEP,
    REG_DEPTH_ONE,
    REG_DEPTH_TWO,
    REG_DEPTH_THREE
  } reg_idx_t;

  typedef enum logic [ALG_W-1:0] {
    ALG_PARALLEL,
    ALG_SERIAL,
    ALG_FEEDBACK
  } alg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_X2,
    ST_T1,
    ST_T2,
    ST_Y,
    ST_S,
    ST_SGN,
    ST_W,
    ST_ACC,
    ST_OFLO,
    ST_OFHI,
    ST_OFSUM,
    ST_OUT
  } state_t;

  // One operator evaluation within a sample tick.
  typedef struct packed {
    logic [1:0] op;       // operator whose sine is taken
    logic       use_off;  // add the pending offset to its phase
    logic       upd;      // advance its accumulator
    logic       acc;      // add to the weighted sum rather than restart it
    logic       do_off;   // turn the weighted sum into an offset
    logic [1:0] tgt;      // operator whose step scales that offset
  } slot_t;

  typedef struct packed {
    state_t state;
    slot_t  slot;
    logic   mul_en;
  } ctl_t;

  // Schedule of operator evaluations for each algorithm; the last is the carrier.
  function automatic slot_t slot_desc(input logic [ALG_W-1:0] alg,
                                      input logic [SLOT_W-1:0] slot);
    slot_t d;
    d = '{op: OP_CARRIER, use_off: 1'b1, upd: 1'b1, acc: 1'b0, do_off: 1'b0,
          tgt: OP_CARRIER};
    case (alg_t'(alg))
      ALG_SERIAL: begin
        case (slot)
          3'd0: d = '{op: OP_THREE, use_off: 1'b0, upd: 1'b1, acc: 1'b0,
                      do_off: 1'b1, tgt: OP_TWO};
          3'd1: d = '{op: OP_TWO, use_off: 1'b1, upd: 1'b1, acc: 1'b0,
                      do_off: 1'b1, tgt: OP_ONE};
          3'd2: d = '{op: OP_ONE, use_off: 1'b1, upd: 1'b1, acc: 1'b0,
                      do_off: 1'b1, tgt: OP_CARRIER};
          default: ;
        endcase
      end
      ALG_FEEDBACK: begin
        case (slot)
          // First look at operator one only sets its own feedback offset.
          3'd0: d = '{op: OP_ONE, use_off: 1'b0, upd: 1'b0, acc: 1'b0,
                      do_off: 1'b1, tgt: OP_ONE};
          3'd1: d = '{op: OP_ONE, use_off: 1'b1, upd: 1'b1, acc: 1'b0,
                      do_off: 1'b0, tgt: OP_CARRIER};
          3'd2: d = '{op: OP_TWO, use_off: 1'b0, upd: 1'b1, acc: 1'b1,
                      do_off: 1'b0, tgt: OP_CARRIER};
          3'd3: d = '{op: OP_THREE, use_off: 1'b0, upd: 1'b1, acc: 1'b1,
                      do_off: 1'b1, tgt: OP_CARRIER};
          default: ;
        endcase
      end
      default: begin
        case (slot)
          3'd0: d = '{op: OP_ONE, use_off: 1'b0, upd: 1'b1, acc: 1'b0,
                      do_off: 1'b0, tgt: OP_CARRIER};
          3'd1: d = '{op: OP_TWO, use_off: 1'b0, upd: 1'b1, acc: 1'b1,
                      do_off: 1'b0, tgt: OP_CARRIER};
          3'd2: d = '{op: OP_THREE, use_off: 1'b0, upd: 1'b1, acc: 1'b1,
                      do_off: 1'b1, tgt: OP_CARRIER};
          default: ;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

/* sv/fm_four_operator_voice_core.sv */
// Top level of the four-operator FM voice: registers, phase accumulators and shared datapath.
//
//   channel  direction  signals                        word
//   in       sink       in_valid in_ready in_amplitude  one amplitude per sample tick
//   out      source     out_valid out_ready out_sample  one signed sample
//   cfg      sink       cfg_we cfg_index cfg_data       one register write, no wait
//
// One 32x18 multiplier evaluates every sine polynomial (five products), every depth
// product, both halves of each offset and the output.
// Reset clears the configuration registers, the phase accumulators and the output valid
// flag, not the datapath working registers; no clearing pass is needed. A held output
// word stalls only the final write; the next word may be accepted as soon as the result sits in the output register.
module fm_four_operator_voice_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [fmv_pkg::AMP_W-1:0]              in_amplitude,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fmv_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                   cfg_we,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fmv_pkg::CFG_W-1:0]              cfg_data
);

  localparam int PB = fmv_pkg::PHASE_BITS;

  fmv_pkg::ctl_t                          ctl;
  logic                                   start;
  logic                                   out_free;

  logic [fmv_pkg::ALG_W-1:0]              alg_r;
  logic [PB-1:0]                          step_r [4];
  logic [fmv_pkg::DEPTH_W-1:0]            depth_one_r, depth_two_r, depth_three_r;
  logic [PB-1:0]                          ph_r [4];

  logic [PB-1:0]                          sph_r, off_r;
  logic [fmv_pkg::X_W-1:0]                x2_r;
  logic signed [fmv_pkg::SIN_W-1:0]       sin_r;
  logic signed [fmv_pkg::W_W-1:0]         w_r;
  logic [fmv_pkg::ACC_W-1:0]              acc_r;
  logic signed [fmv_pkg::PROD_W-1:0]      prod_r;
  logic [fmv_pkg::AMP_W-1:0]              amp_r;
  logic                                   out_valid_r;
  logic [fmv_pkg::SAMPLE_BITS-1:0]        out_sample_r;

  logic [1:0]                             quad;
  logic [fmv_pkg::FRAC_BITS-1:0]          frac;
  logic [fmv_pkg::X_W-1:0]                x_base, x;
  logic [fmv_pkg::X_W-1:0]                poly_hi;
  logic [fmv_pkg::X_W+fmv_pkg::POLY_SHIFT-1:0] s_round;
  logic [fmv_pkg::X_W-1:0]                s_mag;
  logic signed [fmv_pkg::SIN_W-1:0]       s_clip, sin_val;
  logic [PB-1:0]                          sel_ph, sel_step, tgt_step;
  logic [fmv_pkg::DEPTH_W-1:0]            sel_depth;
  logic signed [fmv_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [fmv_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [fmv_pkg::EXT_W-1:0]       prod_ext;
  logic [fmv_pkg::ACC_W-1:0]              off_sum;

  fmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .alg      (alg_r),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign in_ready   = (ctl.state == fmv_pkg::ST_IDLE);
  assign start      = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r         <= '0;
      step_r[0]     <= '0;
      step_r[1]     <= '0;
      step_r[2]     <= '0;
      step_r[3]     <= '0;
      depth_one_r   <= '0;
      depth_two_r   <= '0;
      depth_three_r <= '0;
    end else if (cfg_we) begin
      case (fmv_pkg::reg_idx_t'(cfg_index))
        fmv_pkg::REG_ALGORITHM:      alg_r         <= cfg_data[fmv_pkg::ALG_W-1:0];
        fmv_pkg::REG_CARRIER_STEP:   step_r[0]     <= cfg_data[PB-1:0];
        fmv_pkg::REG_MOD_ONE_STEP:   step_r[1]     <= cfg_data[PB-1:0];
        fmv_pkg::REG_MOD_TWO_STEP:   step_r[2]     <= cfg_data[PB-1:0];
        fmv_pkg::REG_MOD_THREE_STEP: step_r[3]     <= cfg_data[PB-1:0];
        fmv_pkg::REG_DEPTH_ONE:      depth_one_r   <= cfg_data[fmv_pkg::DEPTH_W-1:0];
        fmv_pkg::REG_DEPTH_TWO:      depth_two_r   <= cfg_data[fmv_pkg::DEPTH_W-1:0];
        fmv_pkg::REG_DEPTH_THREE:    depth_three_r <= cfg_data[fmv_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign sel_ph   = ph_r[ctl.slot.op];
  assign sel_step = step_r[ctl.slot.op];
  assign tgt_step = step_r[ctl.slot.tgt];

  always_comb begin
    case (ctl.slot.op)
      fmv_pkg::OP_ONE: sel_depth = depth_one_r;
      fmv_pkg::OP_TWO: sel_depth = depth_two_r;
      default:         sel_depth = depth_three_r;
    endcase
  end

  // Table index of the held phase: quadrant and position within it.
  assign quad   = sph_r[PB-1 -: 2];
  assign frac   = sph_r[PB-3 -: fmv_pkg::FRAC_BITS];
  assign x_base = {1'b0, frac, {fmv_pkg::X_SHIFT{1'b0}}};
  assign x      = quad[0] ? (fmv_pkg::X_ONE - x_base) : x_base;

  assign poly_hi = prod_r[fmv_pkg::POLY_SHIFT +: fmv_pkg::X_W];
  assign s_round = prod_r[fmv_pkg::X_W+fmv_pkg::POLY_SHIFT-1:0] + fmv_pkg::ROUND_HALF;
  assign s_mag   = s_round[fmv_pkg::POLY_SHIFT +: fmv_pkg::X_W];
  assign s_clip  = (s_mag > fmv_pkg::SIN_MAX) ? fmv_pkg::SIN_W'(fmv_pkg::SIN_MAX)
                                              : fmv_pkg::SIN_W'(s_mag);
  assign sin_val = quad[1] ? -s_clip : s_clip;

  assign prod_ext = fmv_pkg::EXT_W'(prod_r);
  // Low half product sits in acc_r; the high half is weighted by the low half's width.
  assign off_sum  = acc_r + (prod_ext[fmv_pkg::ACC_W-1:0] << fmv_pkg::STEP_LO_BITS);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.state)
      fmv_pkg::ST_X2: begin
        mul_a = fmv_pkg::MUL_A_W'(x);
        mul_b = fmv_pkg::MUL_B_W'(x);
      end
      fmv_pkg::ST_T1: begin
        mul_a = fmv_pkg::MUL_A_W'(fmv_pkg::POLY_C);
        mul_b = fmv_pkg::MUL_B_W'(poly_hi);
      end
      fmv_pkg::ST_T2: begin
        mul_a = fmv_pkg::MUL_A_W'(fmv_pkg::POLY_B - poly_hi);
        mul_b = fmv_pkg::MUL_B_W'(x2_r);
      end
      fmv_pkg::ST_Y: begin
        mul_a = fmv_pkg::MUL_A_W'(fmv_pkg::POLY_A - poly_hi);
        mul_b = fmv_pkg::MUL_B_W'(x);
      end
      fmv_pkg::ST_S: begin
        mul_a = fmv_pkg::MUL_A_W'(poly_hi);
        mul_b = fmv_pkg::MUL_B_W'(fmv_pkg::SIN_SCALE);
      end
      fmv_pkg::ST_W: begin
        mul_a = fmv_pkg::MUL_A_W'(sin_r);
        if (ctl.slot.op == fmv_pkg::OP_CARRIER) begin
          mul_b = fmv_pkg::MUL_B_W'(amp_r);
        end else begin
          mul_b = fmv_pkg::MUL_B_W'(sel_depth);
        end
      end
      fmv_pkg::ST_OFLO: begin
        mul_a = fmv_pkg::MUL_A_W'(w_r);
        mul_b = fmv_pkg::MUL_B_W'(tgt_step[fmv_pkg::STEP_LO_BITS-1:0]);
      end
      fmv_pkg::ST_OFHI: begin
        mul_a = fmv_pkg::MUL_A_W'(w_r);
        mul_b = fmv_pkg::MUL_B_W'(tgt_step[fmv_pkg::STEP_LO_BITS +: fmv_pkg::STEP_HI_BITS]);
      end
      default: ;
    endcase
  end

  // Phase accumulators advance once the modulated phase has been captured.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r[0] <= '0;
      ph_r[1] <= '0;
      ph_r[2] <= '0;
      ph_r[3] <= '0;
    end else if (ctl.state == fmv_pkg::ST_X2 && ctl.slot.upd) begin
      ph_r[ctl.slot.op] <= sph_r + sel_step;
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    case (ctl.state)
      fmv_pkg::ST_IDLE: begin
        if (start) begin
          amp_r <= in_amplitude;
        end
      end
      fmv_pkg::ST_LOAD:  sph_r <= sel_ph + (ctl.slot.use_off ? off_r : '0);
      fmv_pkg::ST_T1:    x2_r  <= poly_hi;
      fmv_pkg::ST_SGN:   sin_r <= sin_val;
      fmv_pkg::ST_ACC:   w_r   <= (ctl.slot.acc ? w_r : '0) + fmv_pkg::W_W'(prod_r);
      fmv_pkg::ST_OFHI:  acc_r <= prod_ext[fmv_pkg::ACC_W-1:0];
      fmv_pkg::ST_OFSUM: off_r <= off_sum[fmv_pkg::ACC_W-1:fmv_pkg::OFFSET_SHIFT];
      default: ;
    endcase
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.state == fmv_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.state == fmv_pkg::ST_OUT && out_free) begin
      out_sample_r <= prod_r[fmv_pkg::OUT_MSB -: fmv_pkg::SAMPLE_BITS];
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input accepted while a word was already in progress");

  a_out_from_carrier: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.state == fmv_pkg::ST_OUT |-> ctl.slot.op == fmv_pkg::OP_CARRIER)
    else $error("output stage reached before the carrier was evaluated");

  a_idle_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.state == fmv_pkg::ST_IDLE |=> $stable(ph_r[0]))
    else $error("carrier phase moved while the voice was idle");

  a_out_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.state) == fmv_pkg::ST_OUT)
    else $error("output word appeared outside the output stage");
`endif

endmodule

/* sv/fmv_ctrl.sv */
// Sequencer that steps the shared multiplier through each operator of a sample tick.
module fmv_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fmv_pkg::ALG_W-1:0]  alg,
  input  logic                       out_free,
  output fmv_pkg::ctl_t              ctl
);

  fmv_pkg::state_t                state_r, state_nxt;
  logic [fmv_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  fmv_pkg::slot_t                 cur;

  assign cur = fmv_pkg::slot_desc(alg, slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmv_pkg::ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    case (state_r)
      fmv_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fmv_pkg::ST_LOAD;
          slot_nxt  = '0;
        end
      end
      fmv_pkg::ST_LOAD: state_nxt = fmv_pkg::ST_X2;
      fmv_pkg::ST_X2:   state_nxt = fmv_pkg::ST_T1;
      fmv_pkg::ST_T1:   state_nxt = fmv_pkg::ST_T2;
      fmv_pkg::ST_T2:   state_nxt = fmv_pkg::ST_Y;
      fmv_pkg::ST_Y:    state_nxt = fmv_pkg::ST_S;
      fmv_pkg::ST_S:    state_nxt = fmv_pkg::ST_SGN;
      fmv_pkg::ST_SGN:  state_nxt = fmv_pkg::ST_W;
      fmv_pkg::ST_W: begin
        if (cur.op == fmv_pkg::OP_CARRIER) begin
          state_nxt = fmv_pkg::ST_OUT;
        end else begin
          state_nxt = fmv_pkg::ST_ACC;
        end
      end
      fmv_pkg::ST_ACC: begin
        if (cur.do_off) begin
          state_nxt = fmv_pkg::ST_OFLO;
        end else begin
          state_nxt = fmv_pkg::ST_LOAD;
          slot_nxt  = slot_r + 1'b1;
        end
      end
      fmv_pkg::ST_OFLO: state_nxt = fmv_pkg::ST_OFHI;
      fmv_pkg::ST_OFHI: state_nxt = fmv_pkg::ST_OFSUM;
      fmv_pkg::ST_OFSUM: begin
        state_nxt = fmv_pkg::ST_LOAD;
        slot_nxt  = slot_r + 1'b1;
      end
      fmv_pkg::ST_OUT: begin
        // Wait here while the previous word is still held at the output.
        if (out_free) begin
          state_nxt = fmv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.state  = state_r;
    ctl.slot   = cur;
    ctl.mul_en = state_r inside {fmv_pkg::ST_X2, fmv_pkg::ST_T1, fmv_pkg::ST_T2,
                                 fmv_pkg::ST_Y, fmv_pkg::ST_S, fmv_pkg::ST_W,
                                 fmv_pkg::ST_OFLO, fmv_pkg::ST_OFHI};
  end

endmodule
